/* hdl/wla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_pkg: shared constants for the windowed latency average
// Item kinds, register indexes and fixed port widths.
// ----------------------------------------------------------------------------
package wla_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  // item kind carried in s_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_GAP       = 2'd2;

endpackage

/* hdl/wla_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/wla_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_div: restoring radix-2 divider
// One quotient bit per cycle; done follows the last step.
// ----------------------------------------------------------------------------
module wla_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      // quotient is final the cycle after the last step
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

/* hdl/windowed_latency_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_latency_average: moving average of recent latency samples
// Mean of the last DEPTH samples plus a saturating tick count since the last
// sample, with slow and stale flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one word per item: s_tuser is the kind (0 = latency
//   sample in s_tdata, 1 = one millisecond tick). Every item returns one
//   word on m_*: mean, slow flag, stale flag and elapsed ticks.
//   cfg_we/cfg_index/cfg_data write initial_latency (0), slow_limit (1) and
//   stale_gap (2); write only while the block is idle.
// Timing:
//   The mean comes from a shared bit-serial divider, one quotient bit per
//   cycle over the 16+log2(DEPTH) bit sum. A sample passes through ring RAM
//   read, divider load, the divider steps, seeing the divider done, loading
//   the output register and returning to idle to take the next word. The
//   result appears as the block returns to idle. A tick skips the RAM read;
//   before the first sample it skips the divider too.
// Reset clears the sum, counts and tick counter; ring contents are not
// cleared since unfilled slots are never used. A finished result waits in the
// output register while m_tready is low; the block then takes the next item
// but holds its result until that word is taken.
// ----------------------------------------------------------------------------
module windowed_latency_average #(
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [wla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wla_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wla_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] latency_sample
  input  logic [0:0]                        s_tuser,   // [0] op
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] mean_latency, [16] slow_flag, [17] stale_flag,
  // [49:18] elapsed_ticks, [55:50] zero
  output logic [wla_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = wla_pkg::SAMPLE_W + $clog2(DEPTH);
  localparam int SW    = wla_pkg::SAMPLE_W;
  localparam int TW    = wla_pkg::TICK_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state;

  // configuration
  logic [SW-1:0]    initial_latency;
  logic [SW-1:0]    slow_limit;
  logic [TW-1:0]    stale_gap;

  // window state
  logic [PTR_W-1:0] wr_pos;
  logic [CNT_W-1:0] held;
  logic [SUM_W-1:0] running_sum;
  logic [TW-1:0]    tick_counter;

  // item in flight
  logic [SW-1:0]    sample_q;
  logic [SW-1:0]    mean_q;

  // output register
  logic [SW-1:0]    out_mean;
  logic             out_slow;
  logic             out_stale;
  logic [TW-1:0]    out_ticks;

  logic             accept;
  logic             ring_full;
  logic [SW-1:0]    ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ring_full = (held == CNT_W'(DEPTH));
  assign div_start = (state == ST_START) && (held != '0);

  assign m_tdata = {{(wla_pkg::OUT_TDATA_W - SW - 2 - TW){1'b0}},
                    out_ticks, out_stale, out_slow, out_mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_latency <= '0;
      slow_limit      <= '1;
      stale_gap       <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        wla_pkg::REG_INITIAL_LATENCY: initial_latency <= cfg_data[SW-1:0];
        wla_pkg::REG_SLOW_LIMIT:      slow_limit      <= cfg_data[SW-1:0];
        wla_pkg::REG_STALE_GAP:       stale_gap       <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  wla_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (wr_pos),
    .wdata (sample_q),
    .re    (accept),
    .raddr (wr_pos),
    .rdata (ram_rdata)
  );

  wla_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (running_sum),
    .den   (held),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wr_pos       <= '0;
      held         <= '0;
      running_sum  <= '0;
      tick_counter <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sample_q <= s_tdata[SW-1:0];
            if (s_tuser[0] == wla_pkg::OP_SAMPLE) begin
              state <= ST_READ;
            end else begin
              if (tick_counter != '1) begin
                tick_counter <= tick_counter + TW'(1);
              end
              state <= ST_START;
            end
          end
        end
        ST_READ: begin
          // ram_rdata holds the oldest sample, evicted once the ring is full
          running_sum  <= running_sum - (ring_full ? SUM_W'(ram_rdata) : '0)
                          + SUM_W'(sample_q);
          if (!ring_full) begin
            held <= held + CNT_W'(1);
          end
          wr_pos       <= (wr_pos == PTR_W'(DEPTH - 1)) ? '0 : wr_pos + PTR_W'(1);
          tick_counter <= '0;
          state        <= ST_START;
        end
        ST_START: begin
          if (held == '0) begin
            mean_q <= initial_latency;
            state  <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            // mean of samples never exceeds 16 bits, upper quotient bits are zero
            mean_q <= div_quo[SW-1:0];
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_mean  <= mean_q;
      out_slow  <= (mean_q > slow_limit);
      out_stale <= (tick_counter > stale_gap);
      out_ticks <= tick_counter;
    end
  end

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("sample count beyond ring depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (running_sum == '0))
    else $error("nonzero sum with no samples held");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item taken while one is in flight");
`endif

endmodule
